/* design/ffha_pkg.sv */
// Shared constants, command and status types for the first-fit heap allocator.
`default_nettype none

package ffha_pkg;

  localparam int HEAP_WORDS = 2048;
  localparam int IDX_W      = $clog2(HEAP_WORDS);
  localparam int OFF_W      = 11;
  localparam int HDR_W      = OFF_W + 1;
  localparam int BYTES_W    = 15;
  localparam int WORDS_W    = BYTES_W - 2;
  localparam int SUM_W      = OFF_W + 1;
  localparam int WIDE_W     = OFF_W + 2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic RES_OK    = 1'b0;
  localparam logic RES_NOFIT = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_A_RD,
    ST_A_EVAL,
    ST_A_SPLIT,
    ST_F_CHK,
    ST_F_EVAL,
    ST_F_RD2,
    ST_F_EVAL2
  } state_t;

  typedef enum logic [3:0] {
    MEM_NONE,
    MEM_RD_WALK,
    MEM_RD_H,
    MEM_RD_NXT,
    MEM_WR_CLEAR,
    MEM_WR_OCC_EXACT,
    MEM_WR_SPLIT,
    MEM_WR_HEAD_SPLIT,
    MEM_WR_FREE_H,
    MEM_WR_MERGE
  } mem_op_t;

  typedef struct packed {
    logic    load;
    logic    clr_step;
    logic    advance;
    logic    latch_off;
    logic    finish;
    logic    fail;
    logic    grant;
    mem_op_t mem_op;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic walk_end;
    logic off_zero;
    logic fits;
    logic exact;
    logic split_ok;
    logic rel_bad;
    logic nxt_out;
    logic merge_ok;
  } dp_stat_t;

endpackage

`default_nettype wire

/* design/ffha_ctrl.sv */
// Controller state machine: clearing pass, first-fit walk and free with merge.
`default_nettype none

module ffha_ctrl
  import ffha_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire logic     op,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd,
  output logic          busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (stat.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_next = (op == OP_FREE) ? ST_F_CHK : ST_A_RD;
      end
      ST_A_RD: begin
        state_next = stat.walk_end ? ST_IDLE : ST_A_EVAL;
      end
      ST_A_EVAL: begin
        if (stat.off_zero) begin
          state_next = ST_IDLE;
        end else if (stat.fits) begin
          state_next = stat.exact ? ST_IDLE : ST_A_SPLIT;
        end else begin
          state_next = ST_A_RD;
        end
      end
      ST_A_SPLIT:  state_next = ST_IDLE;
      ST_F_CHK:    state_next = stat.rel_bad ? ST_IDLE : ST_F_EVAL;
      ST_F_EVAL:   state_next = stat.nxt_out ? ST_IDLE : ST_F_RD2;
      ST_F_RD2:    state_next = ST_F_EVAL2;
      ST_F_EVAL2:  state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    cmd.mem_op = MEM_NONE;
    busy = (state != ST_IDLE);
    case (state)
      ST_CLEAR: begin
        cmd.mem_op   = MEM_WR_CLEAR;
        cmd.clr_step = 1'b1;
      end
      ST_IDLE: begin
        cmd.load = start;
      end
      ST_A_RD: begin
        if (stat.walk_end) begin
          cmd.finish = 1'b1;
          cmd.fail   = RES_NOFIT;
        end else begin
          cmd.mem_op = MEM_RD_WALK;
        end
      end
      ST_A_EVAL: begin
        if (stat.off_zero) begin
          cmd.finish = 1'b1;
          cmd.fail   = RES_NOFIT;
        end else if (stat.fits) begin
          if (stat.exact) begin
            cmd.mem_op = MEM_WR_OCC_EXACT;
            cmd.finish = 1'b1;
            cmd.grant  = 1'b1;
          end else if (stat.split_ok) begin
            cmd.mem_op = MEM_WR_SPLIT;
          end
        end else begin
          cmd.advance = 1'b1;
        end
      end
      ST_A_SPLIT: begin
        cmd.mem_op = MEM_WR_HEAD_SPLIT;
        cmd.finish = 1'b1;
        cmd.grant  = 1'b1;
      end
      ST_F_CHK: begin
        if (stat.rel_bad) begin
          cmd.finish = 1'b1;
        end else begin
          cmd.mem_op = MEM_RD_H;
        end
      end
      ST_F_EVAL: begin
        cmd.mem_op    = MEM_WR_FREE_H;
        cmd.latch_off = 1'b1;
        cmd.finish    = stat.nxt_out;
      end
      ST_F_RD2: begin
        cmd.mem_op = MEM_RD_NXT;
      end
      ST_F_EVAL2: begin
        if (stat.merge_ok) cmd.mem_op = MEM_WR_MERGE;
        cmd.finish = 1'b1;
      end
      default: begin
        cmd.mem_op = MEM_NONE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/ffha_dp.sv */
// Datapath: header memory, walk and request registers, result registers.
`default_nettype none

module ffha_dp
  import ffha_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire dp_cmd_t            cmd,
  input  wire logic [BYTES_W-1:0] request_bytes,
  input  wire logic [OFF_W-1:0]   release_index,
  output dp_stat_t                stat,
  output logic                    done,
  output logic                    result_code,
  output logic [OFF_W-1:0]        granted_index
);

  logic [HDR_W-1:0]   mem [HEAP_WORDS];
  logic [HDR_W-1:0]   rdata;
  logic [SUM_W-1:0]   walk;
  logic [WORDS_W-1:0] words;
  logic [OFF_W-1:0]   rel;
  logic [OFF_W-1:0]   off_r;
  logic [IDX_W-1:0]   clr;

  logic [IDX_W-1:0]   addr;
  logic [HDR_W-1:0]   wdata;
  logic               we;

  logic [OFF_W-1:0]   rd_off;
  logic               rd_occ;
  logic [WORDS_W-1:0] avail;
  logic [OFF_W-1:0]   hdr_pos;
  logic [SUM_W-1:0]   nxt_pos;
  logic [SUM_W-1:0]   nxt_reg;
  logic [WORDS_W:0]   split_pos;
  logic [WIDE_W-1:0]  merge_sum;
  logic [SUM_W-1:0]   walk_sum;
  logic [HDR_W-1:0]   clr_val;
  logic [BYTES_W:0]   bytes_up;

  assign rd_off    = rdata[OFF_W-1:0];
  assign rd_occ    = rdata[OFF_W];
  assign avail     = WORDS_W'(rd_off) - WORDS_W'(1);
  assign hdr_pos   = rel - OFF_W'(1);
  assign nxt_pos   = SUM_W'(hdr_pos) + SUM_W'(rd_off);
  assign nxt_reg   = SUM_W'(hdr_pos) + SUM_W'(off_r);
  assign split_pos = (WORDS_W+1)'(walk) + (WORDS_W+1)'(words) + (WORDS_W+1)'(1);
  assign merge_sum = WIDE_W'(hdr_pos) + WIDE_W'(off_r) + WIDE_W'(rd_off);
  assign walk_sum  = walk + SUM_W'(rd_off);
  assign bytes_up  = (BYTES_W+1)'(request_bytes) + (BYTES_W+1)'(7);

  always_comb begin
    if (clr == '0) begin
      clr_val = {1'b0, OFF_W'(HEAP_WORDS - 1)};
    end else if (clr == IDX_W'(HEAP_WORDS - 1)) begin
      clr_val = {1'b1, OFF_W'(0)};
    end else begin
      clr_val = '0;
    end
  end

  always_comb begin
    stat.clear_last = (clr == IDX_W'(HEAP_WORDS - 1));
    stat.walk_end   = (walk >= SUM_W'(HEAP_WORDS));
    stat.off_zero   = (rd_off == '0);
    stat.fits       = !rd_occ && (avail >= words);
    stat.exact      = (avail == words);
    stat.split_ok   = (split_pos < (WORDS_W+1)'(HEAP_WORDS));
    stat.rel_bad    = (rel == '0) || (SUM_W'(hdr_pos) >= SUM_W'(HEAP_WORDS));
    stat.nxt_out    = (nxt_pos >= SUM_W'(HEAP_WORDS));
    stat.merge_ok   = !rd_occ && (merge_sum <= WIDE_W'(HEAP_WORDS - 1));
  end

  always_comb begin
    addr  = walk[IDX_W-1:0];
    wdata = '0;
    we    = 1'b0;
    case (cmd.mem_op)
      MEM_NONE:    addr = walk[IDX_W-1:0];
      MEM_RD_WALK: addr = walk[IDX_W-1:0];
      MEM_RD_H:    addr = hdr_pos[IDX_W-1:0];
      MEM_RD_NXT:  addr = nxt_reg[IDX_W-1:0];
      MEM_WR_CLEAR: begin
        addr  = clr;
        wdata = clr_val;
        we    = 1'b1;
      end
      MEM_WR_OCC_EXACT: begin
        addr  = walk[IDX_W-1:0];
        wdata = {1'b1, rd_off};
        we    = 1'b1;
      end
      MEM_WR_SPLIT: begin
        addr  = split_pos[IDX_W-1:0];
        wdata = {1'b0, rd_off - OFF_W'(words) - OFF_W'(1)};
        we    = 1'b1;
      end
      MEM_WR_HEAD_SPLIT: begin
        addr  = walk[IDX_W-1:0];
        wdata = {1'b1, OFF_W'(words) + OFF_W'(1)};
        we    = 1'b1;
      end
      MEM_WR_FREE_H: begin
        addr  = hdr_pos[IDX_W-1:0];
        wdata = {1'b0, rd_off};
        we    = 1'b1;
      end
      MEM_WR_MERGE: begin
        addr  = hdr_pos[IDX_W-1:0];
        wdata = {1'b0, off_r + rd_off};
        we    = 1'b1;
      end
      default: begin
        addr  = walk[IDX_W-1:0];
        wdata = '0;
        we    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr  <= '0;
      done <= 1'b0;
    end else begin
      if (cmd.clr_step) clr <= clr + IDX_W'(1);
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      walk  <= '0;
      words <= bytes_up[BYTES_W:3];
      rel   <= release_index;
    end else if (cmd.advance) begin
      walk <= walk_sum;
    end
    if (cmd.latch_off) off_r <= rd_off;
    if (cmd.finish) begin
      result_code   <= cmd.fail;
      granted_index <= cmd.grant ? OFF_W'(walk + SUM_W'(1)) : '0;
    end
  end

endmodule

`default_nettype wire

/* design/first_fit_heap_allocator_top.sv */
// Top level of the first-fit heap allocator: controller plus datapath.
//
// After reset the block is busy while it clears the header memory and lays
// down one free block spanning the heap and the end marker.
// An item is taken when start is high and busy is low. The time an allocate
// takes grows with the number of headers visited, since the walk reads one
// header at a time through the single memory port.
// The result appears on result_code and granted_index for one cycle with
// done high, in the first cycle with busy low; it must be taken then. A new
// start may be given in that same cycle.
`default_nettype none

module first_fit_heap_allocator_top
  import ffha_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               op,
  input  wire logic [BYTES_W-1:0] request_bytes,
  input  wire logic [OFF_W-1:0]   release_index,
  output logic                    done,
  output logic                    result_code,
  output logic [OFF_W-1:0]        granted_index
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ffha_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (op),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  ffha_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .request_bytes (request_bytes),
    .release_index (release_index),
    .stat          (stat),
    .done          (done),
    .result_code   (result_code),
    .granted_index (granted_index)
  );

endmodule

`default_nettype wire

/* design/ffha_checker.sv */
// Port-level checker for the first-fit heap allocator, bound to the top level.
`default_nettype none

module ffha_checker
  import ffha_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               op,
  input wire logic [BYTES_W-1:0] request_bytes,
  input wire logic [OFF_W-1:0]   release_index,
  input wire logic               done,
  input wire logic               result_code,
  input wire logic [OFF_W-1:0]   granted_index
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two result beats in a row");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (result_code == RES_NOFIT)) |-> (granted_index == '0))
    else $error("failed allocate returned a nonzero index");

endmodule

bind first_fit_heap_allocator_top ffha_checker u_ffha_checker (.*);

`default_nettype wire

/* sim/first_fit_heap_allocator_top_tb.sv */
// Self-checking testbench for the first-fit heap allocator: directed and random alloc/free vs a header model.
`timescale 1ns / 100ps

module first_fit_heap_allocator_top_tb;
  import ffha_pkg::*;

  localparam int RANDOM_ITEMS = 1030;
  localparam int LIVE_CAP     = 48;
  localparam int SETTLE       = 2 * HEAP_WORDS + 100;
  localparam int LIMIT        = HEAP_WORDS + 1100 * (2 * HEAP_WORDS + 8 + 100) * 3;

  typedef struct packed {
    logic               op;
    logic [BYTES_W-1:0] bytes;
    logic [OFF_W-1:0]   rel;
  } request_t;

  typedef struct packed {
    logic             code;
    logic [OFF_W-1:0] index;
  } grant_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               op = OP_ALLOC;
  logic [BYTES_W-1:0] request_bytes = '0;
  logic [OFF_W-1:0]   release_index = '0;
  logic               busy;
  logic               done;
  logic               result_code;
  logic [OFF_W-1:0]   granted_index;

  logic [HDR_W-1:0] heap_hdr [HEAP_WORDS];
  request_t         pending[$];
  grant_t           expected_grants[$];
  logic [OFF_W-1:0] live_blocks[$];

  grant_t   issued_grant;
  grant_t   oldest_grant;
  request_t next_req;
  int       issued = 0;
  int       beats_in = 0;
  int       errors = 0;
  int       granted = 0;
  int       refused = 0;
  int       released = 0;
  int       burst_left = 8;
  int       idle_left = 0;
  int       cycles = 0;

  first_fit_heap_allocator_top dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .op            (op),
    .request_bytes (request_bytes),
    .release_index (release_index),
    .done          (done),
    .result_code   (result_code),
    .granted_index (granted_index)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic grant_t heap_apply(input request_t r);
    grant_t res;
    int     words, idx, off, split, h, nxt, noff;
    logic   walk_over;
    res.code  = RES_OK;
    res.index = '0;
    if (r.op == OP_ALLOC) begin
      words = (int'(r.bytes) + 7) >> 3;
      res.code = RES_NOFIT;
      idx = 0;
      walk_over = 1'b0;
      while (idx < HEAP_WORDS && !walk_over) begin
        off = int'(heap_hdr[idx][OFF_W-1:0]);
        if (off == 0) begin
          walk_over = 1'b1;
        end else if (!heap_hdr[idx][OFF_W] && off - 1 >= words) begin
          if (off - 1 == words) begin
            heap_hdr[idx][OFF_W] = 1'b1;
          end else begin
            split = idx + words + 1;
            if (split < HEAP_WORDS) heap_hdr[split] = {1'b0, OFF_W'(off - words - 1)};
            heap_hdr[idx] = {1'b1, OFF_W'(words + 1)};
          end
          res.code  = RES_OK;
          res.index = OFF_W'(idx + 1);
          walk_over = 1'b1;
        end else begin
          idx += off;
        end
      end
    end else if (r.rel != 0 && int'(r.rel) - 1 < HEAP_WORDS) begin
      h = int'(r.rel) - 1;
      off = int'(heap_hdr[h][OFF_W-1:0]);
      heap_hdr[h][OFF_W] = 1'b0;
      nxt = h + off;
      if (nxt < HEAP_WORDS && !heap_hdr[nxt][OFF_W]) begin
        noff = int'(heap_hdr[nxt][OFF_W-1:0]);
        if (h + off + noff <= HEAP_WORDS - 1) heap_hdr[h] = {1'b0, OFF_W'(off + noff)};
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      start         <= 1'b0;
      op            <= OP_ALLOC;
      request_bytes <= '0;
      release_index <= '0;
    end else begin
      if (start && !busy) begin
        issued_grant = heap_apply({op, request_bytes, release_index});
        expected_grants.push_back(issued_grant);
        beats_in++;
        if (op == OP_FREE) begin
          released++;
        end else if (issued_grant.code == RES_OK) begin
          granted++;
          live_blocks.push_back(issued_grant.index);
        end else begin
          refused++;
        end
      end
      if (!start || !busy) begin
        if (idle_left > 0) begin
          idle_left--;
          start <= 1'b0;
        end else if (pending.size() > 0) begin
          next_req = pending.pop_front();
          op            <= next_req.op;
          request_bytes <= next_req.bytes;
          release_index <= next_req.rel;
          start         <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            idle_left  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
          end else begin
            burst_left--;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (expected_grants.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat: expected none, actual code %0d index %0d",
                 $time, result_code, granted_index);
      end else begin
        oldest_grant = expected_grants.pop_front();
        if (result_code !== oldest_grant.code) begin
          errors++;
          $display("%0t: result_code mismatch: expected %0d, actual %0d",
                   $time, oldest_grant.code, result_code);
        end
        if (granted_index !== oldest_grant.index) begin
          errors++;
          $display("%0t: granted_index mismatch: expected %0d, actual %0d",
                   $time, oldest_grant.index, granted_index);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    request_t r;
    int       pick;
    int       k;
    for (int i = 0; i < HEAP_WORDS; i++) heap_hdr[i] = '0;
    heap_hdr[0]              = {1'b0, OFF_W'(HEAP_WORDS - 1)};
    heap_hdr[HEAP_WORDS - 1] = {1'b1, OFF_W'(0)};

    pending.push_back({OP_ALLOC, 15'd16368, 11'd0});
    pending.push_back({OP_ALLOC, 15'd0,     11'd0});
    pending.push_back({OP_ALLOC, 15'h7FFF,  11'd0});
    pending.push_back({OP_FREE,  15'd0,     11'd1});
    pending.push_back({OP_ALLOC, 15'd16376, 11'd0});
    pending.push_back({OP_ALLOC, 15'd16384, 11'd0});
    pending.push_back({OP_ALLOC, 15'd0,     11'd0});
    pending.push_back({OP_ALLOC, 15'd1,     11'd0});
    pending.push_back({OP_ALLOC, 15'd8,     11'd0});
    pending.push_back({OP_ALLOC, 15'd9,     11'd0});
    pending.push_back({OP_ALLOC, 15'd64,    11'd0});
    pending.push_back({OP_ALLOC, 15'd64,    11'd0});
    pending.push_back({OP_FREE,  15'd0,     11'd9});
    pending.push_back({OP_ALLOC, 15'd64,    11'd0});
    pending.push_back({OP_FREE,  15'd0,     11'd18});
    pending.push_back({OP_FREE,  15'd0,     11'd9});
    pending.push_back({OP_FREE,  15'h7FFF,  11'd0});
    pending.push_back({OP_FREE,  15'd0,     11'd2047});
    pending.push_back({OP_FREE,  15'd0,     11'd1});
    pending.push_back({OP_FREE,  15'd0,     11'd2});
    pending.push_back({OP_ALLOC, 15'd0,     11'h7FF});
    pending.push_back({OP_FREE,  15'd0,     11'd1024});
    pending.push_back({OP_ALLOC, 15'd2,     11'd0});
    pending.push_back({OP_FREE,  15'd0,     11'd1366});
    issued = pending.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      while (pending.size() >= 2) @(posedge clk);
      pick    = $urandom_range(0, 99);
      r.bytes = BYTES_W'($urandom);
      r.rel   = OFF_W'($urandom_range(0, HEAP_WORDS - 1));
      if (live_blocks.size() >= LIVE_CAP || (pick < 42 && live_blocks.size() > 0)) begin
        k = $urandom_range(0, live_blocks.size() - 1);
        r.op  = OP_FREE;
        r.rel = live_blocks[k];
        live_blocks.delete(k);
      end else if (pick < 50) begin
        r.op = OP_FREE;
      end else begin
        r.op = OP_ALLOC;
        pick = $urandom_range(0, 99);
        if (pick < 85) r.bytes = BYTES_W'($urandom_range(0, 256));
        else if (pick < 95) r.bytes = BYTES_W'($urandom_range(257, 16384));
      end
      pending.push_back(r);
      issued++;
    end

    while (beats_in < issued) @(posedge clk);
    while (expected_grants.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Ran %0d requests: %0d allocations granted, %0d refused for lack of space,",
             beats_in, granted, refused);
    $display("%0d releases (live blocks, stray indexes and ignored ones), %0d errors",
             released, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
